### hdl/afr_pkg.sv
// afr_pkg: shared types and constants of the API frame receiver.
// No dependencies; used by every other file of the block except afr_if.
`default_nettype none

package afr_pkg;

  // Frame delimiters and type codes
  localparam logic [7:0] START_BYTE   = 8'h7E;
  localparam logic [7:0] TYPE_STATUS  = 8'h89;
  localparam logic [7:0] TYPE_RX16    = 8'h81;
  localparam logic [7:0] TYPE_TX16    = 8'h01;
  localparam logic [7:0] CKSUM_BASE   = 8'hFF;
  localparam logic [7:0] LEN_OVERHEAD = 8'd7;   // type, header, instr, dest bytes
  localparam int         LEN_SLACK    = 11;     // frame length above payload limit

  localparam logic [2:0] STATUS_SKIP = 3'd3;
  localparam logic [2:0] HEADER_SKIP = 3'd4;
  localparam logic [2:0] HDR_SRC_HI  = 3'd4;
  localparam logic [2:0] HDR_SRC_LO  = 3'd3;

  // Config register indexes
  localparam logic [7:0] REG_OWN_ADDR   = 8'd0;
  localparam logic [7:0] REG_BCAST_ADDR = 8'd1;
  localparam logic [7:0] REG_HOST_ADDR  = 8'd2;

  localparam logic [7:0] RST_OWN_ADDR   = 8'd1;
  localparam logic [7:0] RST_BCAST_ADDR = 8'd255;
  localparam logic [7:0] RST_HOST_ADDR  = 8'd0;

  // Event queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TYPE,
    PH_STATUS,
    PH_HEADER,
    PH_INSTR,
    PH_DEST,
    PH_PAYLOAD,
    PH_CHECK
  } afr_phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_ACCEPT    = 2'd1,
    KIND_CKSUM_ERR = 2'd2,
    KIND_LEN_ERR   = 2'd3
  } afr_kind_t;

  // One classified event from the parser
  typedef struct packed {
    afr_kind_t   kind;
    logic [7:0]  data;
    logic [7:0]  instr;
    logic [7:0]  dest;
    logic [15:0] sender;
    logic [7:0]  pay_len;
  } afr_evt_t;

  // Queue status seen by the parser and the output stage
  typedef struct packed {
    logic full;
    logic empty;
  } afr_qstat_t;

endpackage

`default_nettype wire

### hdl/afr_if.sv
// afr_if: valid/ready channel interfaces of the API frame receiver
// (byte input, result output, config write). Depends on nothing.
`default_nettype none

interface afr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  instruction;
  logic [7:0]  slave_address;
  logic [15:0] source_address;
  logic [7:0]  payload_length;
  logic        end_of_frame;
  logic [31:0] frames_received;
  logic [31:0] error_count;

  modport source (output valid, output kind, output data_byte, output instruction,
                  output slave_address, output source_address, output payload_length,
                  output end_of_frame, output frames_received, output error_count,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input instruction,
                  input slave_address, input source_address, input payload_length,
                  input end_of_frame, input frames_received, input error_count,
                  output ready);
endinterface

interface afr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/afr_front.sv
// afr_front: byte parser of the API frame receiver. Holds the address registers
// and pushes one event per emitting byte. Depends on afr_pkg and afr_if.
`default_nettype none

module afr_front #(
  parameter int MAX_DATA = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  afr_in_if.sink              in_ch,
  afr_cfg_if.sink             cfg_ch,
  input  afr_pkg::afr_qstat_t qstat,
  output logic                push,
  output afr_pkg::afr_evt_t   push_evt
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_DATA + afr_pkg::LEN_SLACK);
  localparam logic [7:0]  MAX_PAY = 8'(MAX_DATA);

  afr_pkg::afr_phase_t phase_r, phase_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [7:0]  pay_len_r, pay_len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [2:0]  hdr_left_r, hdr_left_nxt;
  logic [15:0] sender_r, sender_nxt;
  logic [7:0]  instr_r, instr_nxt;
  logic [7:0]  dest_r, dest_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        addressed_r, addressed_nxt;

  logic [7:0] own_r, bcast_r, host_r;

  logic       acc;
  logic [7:0] b;

  assign in_ch.ready  = !qstat.full;
  assign cfg_ch.ready = 1'b1;
  assign acc = in_ch.valid && in_ch.ready;
  assign b   = in_ch.rx_byte;

  // Address registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= afr_pkg::RST_OWN_ADDR;
      bcast_r <= afr_pkg::RST_BCAST_ADDR;
      host_r  <= afr_pkg::RST_HOST_ADDR;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        afr_pkg::REG_OWN_ADDR:   own_r   <= cfg_ch.data;
        afr_pkg::REG_BCAST_ADDR: bcast_r <= cfg_ch.data;
        afr_pkg::REG_HOST_ADDR:  host_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= afr_pkg::PH_HUNT;
      len_hi_r    <= '0;
      pay_len_r   <= '0;
      sum_r       <= '0;
      ftype_r     <= '0;
      hdr_left_r  <= '0;
      sender_r    <= '0;
      instr_r     <= '0;
      dest_r      <= '0;
      left_r      <= '0;
      addressed_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_hi_r    <= len_hi_nxt;
      pay_len_r   <= pay_len_nxt;
      sum_r       <= sum_nxt;
      ftype_r     <= ftype_nxt;
      hdr_left_r  <= hdr_left_nxt;
      sender_r    <= sender_nxt;
      instr_r     <= instr_nxt;
      dest_r      <= dest_nxt;
      left_r      <= left_nxt;
      addressed_r <= addressed_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    len_hi_nxt    = len_hi_r;
    pay_len_nxt   = pay_len_r;
    sum_nxt       = sum_r;
    ftype_nxt     = ftype_r;
    hdr_left_nxt  = hdr_left_r;
    sender_nxt    = sender_r;
    instr_nxt     = instr_r;
    dest_nxt      = dest_r;
    left_nxt      = left_r;
    addressed_nxt = addressed_r;
    push          = 1'b0;
    push_evt.kind = afr_pkg::KIND_PAYLOAD;
    push_evt.data = 8'd0;

    if (acc) begin
      case (phase_r)
        afr_pkg::PH_HUNT: begin
          if (b == afr_pkg::START_BYTE) phase_nxt = afr_pkg::PH_LEN_HI;
        end
        afr_pkg::PH_LEN_HI: begin
          len_hi_nxt = b;
          phase_nxt  = afr_pkg::PH_LEN_LO;
        end
        afr_pkg::PH_LEN_LO: begin
          pay_len_nxt = b - afr_pkg::LEN_OVERHEAD;
          if ({len_hi_r, b} > MAX_LEN) begin
            phase_nxt = afr_pkg::PH_HUNT;
          end else begin
            phase_nxt = afr_pkg::PH_TYPE;
          end
        end
        afr_pkg::PH_TYPE: begin
          ftype_nxt  = b;
          sum_nxt    = b;
          sender_nxt = '0;
          if (b == afr_pkg::TYPE_STATUS) begin
            hdr_left_nxt = afr_pkg::STATUS_SKIP;
            phase_nxt    = afr_pkg::PH_STATUS;
          end else if (b == afr_pkg::TYPE_RX16 || b == afr_pkg::TYPE_TX16) begin
            hdr_left_nxt = afr_pkg::HEADER_SKIP;
            phase_nxt    = afr_pkg::PH_HEADER;
          end else begin
            hdr_left_nxt = '0;
            phase_nxt    = afr_pkg::PH_INSTR;
          end
        end
        afr_pkg::PH_STATUS: begin
          hdr_left_nxt = hdr_left_r - 3'd1;
          if (hdr_left_nxt == 3'd0) phase_nxt = afr_pkg::PH_HUNT;
        end
        afr_pkg::PH_HEADER: begin
          sum_nxt = sum_r + b;
          if (ftype_r == afr_pkg::TYPE_RX16) begin
            if (hdr_left_r == afr_pkg::HDR_SRC_HI) sender_nxt = {b, 8'd0};
            else if (hdr_left_r == afr_pkg::HDR_SRC_LO) sender_nxt = {sender_r[15:8], b};
          end
          hdr_left_nxt = hdr_left_r - 3'd1;
          if (hdr_left_nxt == 3'd0) phase_nxt = afr_pkg::PH_INSTR;
        end
        afr_pkg::PH_INSTR: begin
          instr_nxt = b;
          sum_nxt   = sum_r + b;
          phase_nxt = afr_pkg::PH_DEST;
        end
        afr_pkg::PH_DEST: begin
          dest_nxt      = b;
          sum_nxt       = sum_r + b;
          addressed_nxt = (b == own_r) || (b == bcast_r) || (b == host_r);
          left_nxt      = pay_len_r;
          if (pay_len_r > MAX_PAY) begin
            push          = 1'b1;
            push_evt.kind = afr_pkg::KIND_LEN_ERR;
            phase_nxt     = afr_pkg::PH_HUNT;
          end else if (pay_len_r == 8'd0) begin
            phase_nxt = afr_pkg::PH_CHECK;
          end else begin
            phase_nxt = afr_pkg::PH_PAYLOAD;
          end
        end
        afr_pkg::PH_PAYLOAD: begin
          sum_nxt  = sum_r + b;
          left_nxt = left_r - 8'd1;
          if (left_nxt == 8'd0) phase_nxt = afr_pkg::PH_CHECK;
          if (addressed_r) begin
            push          = 1'b1;
            push_evt.data = b;
          end
        end
        afr_pkg::PH_CHECK: begin
          phase_nxt = afr_pkg::PH_HUNT;
          if (afr_pkg::CKSUM_BASE - sum_r == b) begin
            if (addressed_r) begin
              push          = 1'b1;
              push_evt.kind = afr_pkg::KIND_ACCEPT;
            end
          end else begin
            push          = 1'b1;
            push_evt.kind = afr_pkg::KIND_CKSUM_ERR;
          end
        end
        default: phase_nxt = afr_pkg::PH_HUNT;
      endcase
    end

    // Frame context as it stands after this byte
    push_evt.instr   = instr_nxt;
    push_evt.dest    = dest_nxt;
    push_evt.sender  = sender_nxt;
    push_evt.pay_len = pay_len_nxt;
  end

endmodule

`default_nettype wire

### hdl/afr_queue.sv
// afr_queue: small event FIFO between parser and output stage.
// Depends on afr_pkg.
`default_nettype none

module afr_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  afr_pkg::afr_evt_t   push_evt,
  input  wire                 pop,
  output afr_pkg::afr_evt_t   head_evt,
  output afr_pkg::afr_qstat_t qstat
);

  afr_pkg::afr_evt_t mem_r [afr_pkg::QDEPTH];
  logic [afr_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [afr_pkg::QAW:0]   cnt_r;
  logic do_push, do_pop;

  assign qstat.full  = (cnt_r == (afr_pkg::QAW+1)'(afr_pkg::QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_evt    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/afr_back.sv
// afr_back: output stage of the API frame receiver. Pops events, keeps the
// good/bad frame counters and drives the registered result channel.
// Depends on afr_pkg and afr_if.
`default_nettype none

module afr_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  afr_pkg::afr_evt_t   head_evt,
  input  afr_pkg::afr_qstat_t qstat,
  output logic                pop,
  afr_out_if.source           out_ch
);

  logic              out_valid_r;
  afr_pkg::afr_evt_t evt_r;
  logic [31:0]       good_r, good_nxt;
  logic [31:0]       bad_r, bad_nxt;

  assign pop = !qstat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    good_nxt = good_r;
    bad_nxt  = bad_r;
    case (head_evt.kind)
      afr_pkg::KIND_ACCEPT:    good_nxt = good_r + 32'd1;
      afr_pkg::KIND_CKSUM_ERR: bad_nxt  = bad_r + 32'd1;
      afr_pkg::KIND_LEN_ERR:   bad_nxt  = bad_r + 32'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) evt_r <= head_evt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = evt_r.kind;
  assign out_ch.data_byte       = evt_r.data;
  assign out_ch.instruction     = evt_r.instr;
  assign out_ch.slave_address   = evt_r.dest;
  assign out_ch.source_address  = evt_r.sender;
  assign out_ch.payload_length  = evt_r.pay_len;
  assign out_ch.end_of_frame    = (evt_r.kind != afr_pkg::KIND_PAYLOAD);
  assign out_ch.frames_received = good_r;
  assign out_ch.error_count     = bad_r;

endmodule

`default_nettype wire

### hdl/api_frame_receiver.sv
// api_frame_receiver: top level of the serial API frame parser.
// Depends on afr_pkg, afr_if, afr_front, afr_queue and afr_back.
//
// The receiver takes one byte from the serial link per item and sustains one
// item per clock while the event queue has room: the parser state machine in
// afr_front updates its frame state once per byte, and that per-byte update
// sets the rate. Bytes that produce a result (addressed payload bytes and frame
// verdicts) are pushed into a 4-entry event queue; afr_back pops it into an
// output register and adds the frame counters, so a result reaches out_ch
// through the queue and then the output register. in_ch.ready drops only
// while the queue is full, i.e. after the sink has stalled long enough for
// results to fill it. Payload bytes go out before the frame checksum is known:
// a sink must drop a frame's bytes when its end_of_frame item reports a
// checksum or length error. Address registers (own, broadcast, host) are
// written through cfg_ch, which is always ready; write them only while no
// frame is in flight.
`default_nettype none

module api_frame_receiver #(
  parameter int MAX_DATA = 64
) (
  input  wire       clk,
  input  wire       rst_n,
  afr_in_if.sink    in_ch,
  afr_out_if.source out_ch,
  afr_cfg_if.sink   cfg_ch
);

  logic                push, pop;
  afr_pkg::afr_evt_t   push_evt, head_evt;
  afr_pkg::afr_qstat_t qstat;

  // Parser: classifies every byte, pushes events
  afr_front #(
    .MAX_DATA (MAX_DATA)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .qstat    (qstat),
    .push     (push),
    .push_evt (push_evt)
  );

  // Decouples parser from output backpressure
  afr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head_evt (head_evt),
    .qstat    (qstat)
  );

  // Counters and result register
  afr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_evt (head_evt),
    .qstat    (qstat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
